// ===== hw/rtl/hcs_pkg.sv =====
package hcs_pkg;

   // Number of RF channels in the 79-channel hopping set.
   localparam int unsigned CHANNELS = 79;

   // Field widths.
   localparam int unsigned ADDR_W = 28;
   localparam int unsigned CLK_W  = 28;
   localparam int unsigned CHAN_W = 7;
   localparam int unsigned Z_W    = 5;
   localparam int unsigned CTL_W  = 14;
   localparam int unsigned E_W    = 7;
   localparam int unsigned SUM_W  = 9;

   // The F term is 16 * clk[27:7]. It is reduced mod 79 through a
   // reciprocal multiply followed by one conditional subtract.
   localparam int unsigned U_W        = 25;
   localparam int unsigned FOLD_SHIFT = 32;
   localparam longint unsigned RECIP_L = (64'd1 << FOLD_SHIFT) / CHANNELS;
   localparam int unsigned RECIP_W    = 26;
   localparam int unsigned PROD_W     = U_W + RECIP_W;
   localparam int unsigned Q_W        = PROD_W - FOLD_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   // The butterfly has 14 stages; the upper half runs in one pipe stage,
   // the lower half in the next.
   localparam int unsigned STAGES  = 14;
   localparam int unsigned SPLIT   = 7;

   typedef logic [2:0] lane_type;

   // Bit pairs exchanged by each butterfly stage.
   localparam lane_type SWAP_LO [0:STAGES-1] =
      '{3'd0, 3'd2, 3'd1, 3'd3, 3'd0, 3'd1, 3'd0, 3'd3, 3'd1, 3'd0, 3'd2, 3'd1,
        3'd0, 3'd1};
   localparam lane_type SWAP_HI [0:STAGES-1] =
      '{3'd1, 3'd3, 3'd2, 3'd4, 3'd4, 3'd3, 3'd2, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3,
        3'd3, 3'd2};

   // One butterfly stage: exchange the two selected bits.
   function automatic logic [Z_W-1:0] bfly_step(logic [Z_W-1:0] z, int unsigned s);
      logic [Z_W-1:0] mask;
      mask = (Z_W'(1) << SWAP_LO[s]) | (Z_W'(1) << SWAP_HI[s]);
      if (z[SWAP_LO[s]] != z[SWAP_HI[s]]) begin
         return z ^ mask;
      end
      return z;
   endfunction

endpackage

// ===== hw/rtl/hop_channel_select.sv =====
// Bluetooth basic hop selection, 79-channel connection state. Load the low
// 28 bits of the master address through csr_write_enable/csr_write_data, then
// pulse start with a native clock; one beat per cycle is accepted and busy
// stays low. Each result appears on rsp_channel_index with rsp_valid high for
// exactly one cycle, after its start beat passes the registered stages for
// address terms and the reciprocal multiply, upper butterfly half with the
// mod-79 fix of F, lower butterfly half with the sum, final mod-79 and channel
// bank map. The receiver cannot stall, so it must take every result as it
// comes. The channel frequency is 2402 plus rsp_channel_index MHz.
module hop_channel_select (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hcs_pkg::CLK_W-1:0]     req_native_clock,
   output logic                          rsp_valid,
   output logic [hcs_pkg::CHAN_W-1:0]    rsp_channel_index,
   input  logic                          csr_write_enable,
   input  logic [hcs_pkg::ADDR_W-1:0]    csr_write_data
);

   // Address register.
   logic [hcs_pkg::ADDR_W-1:0] device_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= '0;
      end else if (csr_write_enable) begin
         device_address_ff <= csr_write_data;
      end
   end

   // The pipeline never stalls, so a beat is taken every cycle.
   assign busy = 1'b0;

   // Stage A: form the hop terms and start the F reduction.
   logic                          valid_a_ff;
   logic [hcs_pkg::Z_W-1:0]       z_a_ff, z_a_in;
   logic [hcs_pkg::CTL_W-1:0]     ctl_a_ff, ctl_a_in;
   logic [hcs_pkg::E_W-1:0]       e_a_ff, e_a_in;
   logic                          y1_a_ff;
   logic [hcs_pkg::U_W-1:0]       u_a_ff, u_a_in;
   logic [hcs_pkg::Q_W-1:0]       q_a_ff, q_a_in;
   logic [hcs_pkg::PROD_W-1:0]    prod_a;
   logic [hcs_pkg::Z_W-1:0]       a_term, c_term, x_term;
   logic [3:0]                    b_term;
   logic [8:0]                    d_term;
   logic [hcs_pkg::ADDR_W-1:0]    adr;

   always_comb begin
      adr      = device_address_ff;
      x_term   = req_native_clock[6:2];
      a_term   = adr[27:23] ^ req_native_clock[25:21];
      b_term   = adr[22:19];
      c_term   = {adr[8], adr[6], adr[4], adr[2], adr[0]} ^ req_native_clock[20:16];
      d_term   = adr[18:10] ^ req_native_clock[15:7];
      e_a_in   = {adr[13], adr[11], adr[9], adr[7], adr[5], adr[3], adr[1]};
      z_a_in   = (x_term + a_term) ^ {1'b0, b_term};
      ctl_a_in = {c_term ^ {hcs_pkg::Z_W{req_native_clock[1]}}, d_term};
      u_a_in   = {req_native_clock[27:7], 4'b0000};
      prod_a   = hcs_pkg::PROD_W'(u_a_in) * hcs_pkg::PROD_W'(hcs_pkg::RECIP);
      q_a_in   = prod_a[hcs_pkg::PROD_W-1:hcs_pkg::FOLD_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start && !busy;
      end
      z_a_ff   <= z_a_in;
      ctl_a_ff <= ctl_a_in;
      e_a_ff   <= e_a_in;
      y1_a_ff  <= req_native_clock[1];
      u_a_ff   <= u_a_in;
      q_a_ff   <= q_a_in;
   end

   // Stage B: upper butterfly half and the final fix of F mod 79.
   logic                          valid_b_ff;
   logic [hcs_pkg::Z_W-1:0]       z_b_ff, z_b_in;
   logic [hcs_pkg::SPLIT-1:0]     ctl_b_ff;
   logic [hcs_pkg::E_W-1:0]       e_b_ff;
   logic                          y1_b_ff;
   logic [hcs_pkg::CHAN_W-1:0]    fmod_b_ff, fmod_b_in;
   logic [hcs_pkg::U_W-1:0]       rem_full;
   logic [7:0]                    rem_b;

   always_comb begin
      z_b_in = z_a_ff;
      for (int s = hcs_pkg::STAGES - 1; s >= int'(hcs_pkg::SPLIT); s--) begin
         if (ctl_a_ff[s]) begin
            z_b_in = hcs_pkg::bfly_step(z_b_in, s);
         end
      end
      rem_full = u_a_ff - hcs_pkg::U_W'(hcs_pkg::U_W'(q_a_ff) *
                                        hcs_pkg::U_W'(hcs_pkg::CHANNELS));
      rem_b    = rem_full[7:0];
      if (rem_b >= 8'(hcs_pkg::CHANNELS)) begin
         fmod_b_in = hcs_pkg::CHAN_W'(rem_b - 8'(hcs_pkg::CHANNELS));
      end else begin
         fmod_b_in = hcs_pkg::CHAN_W'(rem_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      z_b_ff    <= z_b_in;
      ctl_b_ff  <= ctl_a_ff[hcs_pkg::SPLIT-1:0];
      e_b_ff    <= e_a_ff;
      y1_b_ff   <= y1_a_ff;
      fmod_b_ff <= fmod_b_in;
   end

   // Stage C: lower butterfly half and the sum of all terms.
   logic                          valid_c_ff;
   logic [hcs_pkg::SUM_W-1:0]     sum_c_ff, sum_c_in;
   logic [hcs_pkg::Z_W-1:0]       perm_c;

   always_comb begin
      perm_c = z_b_ff;
      for (int s = hcs_pkg::SPLIT - 1; s >= 0; s--) begin
         if (ctl_b_ff[s]) begin
            perm_c = hcs_pkg::bfly_step(perm_c, s);
         end
      end
      sum_c_in = hcs_pkg::SUM_W'(perm_c) + hcs_pkg::SUM_W'(e_b_ff) +
                 hcs_pkg::SUM_W'(fmod_b_ff) + {3'b000, y1_b_ff, 5'b00000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_b_ff;
      end
      sum_c_ff <= sum_c_in;
   end

   // Stage D: reduce mod 79 and map through the even-then-odd channel bank.
   logic                          rsp_valid_ff;
   logic [hcs_pkg::CHAN_W-1:0]    chan_ff, chan_in;
   logic [hcs_pkg::CHAN_W-1:0]    k_d;
   logic [hcs_pkg::CHAN_W:0]      dbl_d;

   always_comb begin
      if (sum_c_ff >= hcs_pkg::SUM_W'(3 * hcs_pkg::CHANNELS)) begin
         k_d = hcs_pkg::CHAN_W'(sum_c_ff - hcs_pkg::SUM_W'(3 * hcs_pkg::CHANNELS));
      end else if (sum_c_ff >= hcs_pkg::SUM_W'(2 * hcs_pkg::CHANNELS)) begin
         k_d = hcs_pkg::CHAN_W'(sum_c_ff - hcs_pkg::SUM_W'(2 * hcs_pkg::CHANNELS));
      end else if (sum_c_ff >= hcs_pkg::SUM_W'(hcs_pkg::CHANNELS)) begin
         k_d = hcs_pkg::CHAN_W'(sum_c_ff - hcs_pkg::SUM_W'(hcs_pkg::CHANNELS));
      end else begin
         k_d = hcs_pkg::CHAN_W'(sum_c_ff);
      end
      dbl_d = {k_d, 1'b0};
      if (dbl_d >= (hcs_pkg::CHAN_W + 1)'(hcs_pkg::CHANNELS)) begin
         chan_in = hcs_pkg::CHAN_W'(dbl_d - (hcs_pkg::CHAN_W + 1)'(hcs_pkg::CHANNELS));
      end else begin
         chan_in = hcs_pkg::CHAN_W'(dbl_d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_c_ff;
      end
      chan_ff <= chan_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = chan_ff;

`ifndef SYNTHESIS
   // A result beat always traces back to an earlier start beat.
   a_rsp_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 4))
      else $error("result beat without a matching start beat");

   // The delivered channel lies in the 79-channel set.
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_channel_index < hcs_pkg::CHAN_W'(hcs_pkg::CHANNELS)))
      else $error("channel index out of range");

   // The reduced F term is below 79.
   a_fmod_range: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff |-> (fmod_b_ff < hcs_pkg::CHAN_W'(hcs_pkg::CHANNELS)))
      else $error("F term not fully reduced");

   // The upper butterfly half only moves bits, so the bit count is kept.
   a_bfly_weight: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff |-> ($countones(z_b_ff) == $countones($past(z_a_ff))))
      else $error("butterfly changed the number of set bits");
`endif

endmodule

// ===== tb/hop_channel_select_tb.sv =====
module hop_channel_select_tb;

   localparam int unsigned LIMIT_CYCLES     = 500000;
   localparam int unsigned SETTLE_CYCLES    = 10;
   localparam int unsigned RANDOM_PHASES    = 8;
   localparam int unsigned HOPS_PER_PHASE   = 180;
   localparam logic [hcs_pkg::CLK_W-1:0] CLOCK_MASK = '1;

   // Bit pairs exchanged by the butterfly, stage 0 through stage 13.
   localparam int unsigned PAIR_LO [14] = '{0, 2, 1, 3, 0, 1, 0, 3, 1, 0, 2, 1, 0, 1};
   localparam int unsigned PAIR_HI [14] = '{1, 3, 2, 4, 4, 3, 2, 4, 4, 3, 4, 3, 3, 2};

   // Keeps the hop channels still owed by the block, oldest first.
   class channel_ledger;
      logic [hcs_pkg::ADDR_W-1:0] address;
      logic [hcs_pkg::CHAN_W-1:0] owed_channels[$];
      int unsigned                errors;

      function new();
         address = '0;
         errors  = 0;
      endfunction

      // Basic hop selection for the 79-channel connection state.
      function automatic logic [hcs_pkg::CHAN_W-1:0] predict_channel(
         logic [hcs_pkg::CLK_W-1:0] clk);
         logic [4:0]  x_term, a_term, c_term, z;
         logic [3:0]  b_term;
         logic [8:0]  d_term;
         logic [6:0]  e_term;
         logic [13:0] ctl;
         logic        y1;
         int unsigned f_mod, k;
         x_term = clk[6:2];
         y1     = clk[1];
         a_term = address[27:23] ^ clk[25:21];
         b_term = address[22:19];
         c_term = {address[8], address[6], address[4], address[2], address[0]} ^ clk[20:16];
         d_term = address[18:10] ^ clk[15:7];
         e_term = {address[13], address[11], address[9], address[7], address[5],
                   address[3], address[1]};
         f_mod  = (32'(clk[27:7]) << 4) % hcs_pkg::CHANNELS;
         z      = (x_term + a_term) ^ {1'b0, b_term};
         ctl    = {c_term ^ {5{y1}}, d_term};
         // The top stage acts first.
         for (int s = 13; s >= 0; s--) begin
            if (ctl[s] && (z[PAIR_LO[s]] != z[PAIR_HI[s]])) begin
               z = z ^ ((5'd1 << PAIR_LO[s]) | (5'd1 << PAIR_HI[s]));
            end
         end
         k = (32'(z) + 32'(e_term) + f_mod + (y1 ? 32 : 0)) % hcs_pkg::CHANNELS;
         return hcs_pkg::CHAN_W'((2 * k) % hcs_pkg::CHANNELS);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("%0t: %s", $time, what);
      endtask

      function void note_hop(logic [hcs_pkg::CLK_W-1:0] clk);
         owed_channels.push_back(predict_channel(clk));
      endfunction

      task check_channel(logic [hcs_pkg::CHAN_W-1:0] ch);
         logic [hcs_pkg::CHAN_W-1:0] want;
         if (owed_channels.size() == 0) begin
            report_mismatch($sformatf("channel %0d with no hop owed", ch));
         end else begin
            want = owed_channels.pop_front();
            if (ch !== want) begin
               report_mismatch($sformatf("channel %0d, predicted %0d", ch, want));
            end
         end
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [hcs_pkg::CLK_W-1:0]  req_native_clock;
   logic                       rsp_valid;
   logic [hcs_pkg::CHAN_W-1:0] rsp_channel_index;
   logic                       csr_write_enable;
   logic [hcs_pkg::ADDR_W-1:0] csr_write_data;

   channel_ledger ledger = new();
   int unsigned   cycles = 0;
   logic [hcs_pkg::CLK_W-1:0] hop_clock;
   bit            steady;

   hop_channel_select dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_native_clock  (req_native_clock),
      .rsp_valid         (rsp_valid),
      .rsp_channel_index (rsp_channel_index),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check every result beat and guard against a hang.
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid) begin
         ledger.check_channel(rsp_channel_index);
      end
      if (cycles > LIMIT_CYCLES) begin
         $display("hop_channel_select: mismatch");
         $finish;
      end
   end

   // Present one native clock and hold it until the block takes the beat.
   task send_hop(logic [hcs_pkg::CLK_W-1:0] clk);
      @(negedge clock);
      start            <= 1'b1;
      req_native_clock <= clk;
      do @(posedge clock); while (busy);
      ledger.note_hop(clk);
   endtask

   task hold_off(int unsigned n);
      if (n != 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Wait until every owed channel has come back, then a little longer.
   task drain();
      @(negedge clock);
      start <= 1'b0;
      while (ledger.owed_channels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_address(logic [hcs_pkg::ADDR_W-1:0] value);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      ledger.address = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly short gaps, some long ones, none at all in steady phases.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Clocks mostly advance like a running counter; some jump, sit at extremes or have a single bit set.
   function automatic logic [hcs_pkg::CLK_W-1:0] next_clock();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         hop_clock = hop_clock + hcs_pkg::CLK_W'($urandom_range(1, 2));
      end else if (r < 9) begin
         hop_clock = hcs_pkg::CLK_W'($urandom) & CLOCK_MASK;
      end else begin
         case ($urandom_range(0, 2))
            0: begin
               return '0;
            end
            1: begin
               return CLOCK_MASK;
            end
            default: begin
               return hcs_pkg::CLK_W'(1) << $urandom_range(0, hcs_pkg::CLK_W - 1);
            end
         endcase
      end
      return hop_clock;
   endfunction

   task directed_hops();
      logic [hcs_pkg::CLK_W-1:0] picks [12];
      // Clock bit zero pairs, all-zero, all-one, isolated term fields and alternating bits.
      picks = '{28'h0000000, 28'h0000001, 28'h0000002, 28'h0000003,
                28'h000007C, 28'h000007D, 28'hFFFFFFF, 28'hFFFFFFE,
                28'h01F0000, 28'h3E00000, 28'hAAAAAAA, 28'h5555555};
      foreach (picks[i]) begin
         send_hop(picks[i]);
      end
   endtask

   initial begin
      logic [hcs_pkg::ADDR_W-1:0] phase_address;
      reset            = 1'b1;
      start            = 1'b0;
      req_native_clock = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      hop_clock        = '0;
      steady           = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats at both address extremes.
      write_address('0);
      directed_hops();
      write_address('1);
      directed_hops();

      // Random phases, each under its own address.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               phase_address = 28'hAAAAAAA;
            end
            1: begin
               phase_address = 28'h5555555;
            end
            default: begin
               phase_address = hcs_pkg::ADDR_W'($urandom);
            end
         endcase
         write_address(phase_address);
         steady    = ($urandom_range(0, 3) == 0);
         hop_clock = hcs_pkg::CLK_W'($urandom);
         for (int i = 0; i < HOPS_PER_PHASE; i++) begin
            send_hop(next_clock());
            hold_off(pick_gap());
         end
      end

      drain();
      if (ledger.errors == 0) begin
         $display("hop_channel_select: match");
      end else begin
         $display("hop_channel_select: mismatch");
      end
      $finish;
   end

endmodule

// ===== hop_channel_select.f =====
hw/rtl/hcs_pkg.sv
hw/rtl/hop_channel_select.sv
tb/hop_channel_select_tb.sv
